@@ src/dsm_pkg.sv @@
// Shared types and constants for the DFA string matcher.
package dsm_pkg;

   localparam int STATE_W = 6;
   localparam int SYM_W   = 8;
   localparam int Q_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_MARK  = 2'd1,
      OP_MATCH = 2'd2,
      OP_EMPTY = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [STATE_W-1:0] from_state;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] to_state;
      logic               entry_valid;
      logic               first_symbol;
      logic               last_symbol;
   } req_word_type;

   typedef struct packed {
      logic               accepted;
      logic               missing_transition;
      logic [STATE_W-1:0] end_state;
   } rsp_word_type;

   typedef struct packed {
      op_type             op;
      logic               in_range;
      logic [STATE_W-1:0] from_state;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] to_state;
      logic               entry_valid;
      logic               first_symbol;
      logic               last_symbol;
      logic               has_result;
   } cmd_type;

   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] dest_state;
   } entry_type;

   typedef struct packed {
      logic match;
      logic look;
      logic report;
   } stage_type;

endpackage

@@ src/dfa_string_matcher.sv @@
// Top level of the table-driven DFA string matcher.
//
// Request channel (req_valid / req_stall / req_word) takes one word per cycle:
// transition loads, accepting-mark writes, match symbols and empty-string
// queries. Result channel (rsp_valid / rsp_stall / rsp_word) returns one word
// for each match symbol flagged last and for each empty-string query.
// csr_wr_en / csr_wr_data set the start state; write only while idle.
// Throughput: one request word per cycle while req_stall is low, any mix of
// operations. The bound is the next-state loop: the transition RAM's
// registered read data selects the next read address in the same cycle.
// Result path: an accepted request word goes through the command queue, then
// command issue with RAM lookup, then result queue push, before rsp_valid rises.
// Reset: the transition store is swept clear, all NUM_STATES * 2**SYMBOL_BITS
// entries (16384 by default), with req_stall high; csr writes are still taken.
// Receiver stall: results back up into a two-entry queue, then commands that
// produce results hold in the back end and req_stall rises once the two-entry
// command queue fills.
module dfa_string_matcher import dsm_pkg::*; #(
   parameter int NUM_STATES  = 64,
   parameter int SYMBOL_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_word,
   input  logic               csr_wr_en,
   input  logic [STATE_W-1:0] csr_wr_data
);

   logic    clearing;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   dsm_front #(
      .NUM_STATES  (NUM_STATES),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .clearing  (clearing),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   dsm_back #(
      .NUM_STATES  (NUM_STATES),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule

@@ src/dsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/dsm_fifo.sv @@
// Small register FIFO used for the command queue and the result queue.
module dsm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         valid,
   output logic                         full,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] n;
      if (p == PW'(DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PW'(1);
      end
      return n;
   endfunction

   assign valid    = (count_ff != '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/dsm_front.sv @@
// Front end: accepts request words, decodes them and queues commands.
module dsm_front import dsm_pkg::*; #(
   parameter int NUM_STATES  = 64,
   parameter int SYMBOL_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   input  logic         clearing,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  logic         cmd_pop
);

   localparam logic [SYM_W-1:0] SymMask = SYM_W'((1 << SYMBOL_BITS) - 1);
   localparam int CW = $clog2(Q_DEPTH + 1);

   cmd_type                      dec;
   logic                         q_full;
   logic                         q_push;
   logic [$bits(cmd_type)-1:0]   q_data;
   logic [CW-1:0]                q_count;

   always_comb begin
      dec.op           = req_word.op;
      dec.in_range     = (32'(req_word.from_state) < 32'(NUM_STATES));
      dec.from_state   = req_word.from_state;
      dec.symbol       = req_word.symbol & SymMask;
      dec.to_state     = req_word.to_state;
      dec.entry_valid  = req_word.entry_valid;
      dec.first_symbol = req_word.first_symbol;
      dec.last_symbol  = req_word.last_symbol;
      dec.has_result   = (req_word.op == OP_EMPTY) ||
                         ((req_word.op == OP_MATCH) && req_word.last_symbol);
   end

   assign req_stall = q_full | clearing;
   assign q_push    = req_valid & ~req_stall;
   assign cmd       = cmd_type'(q_data);

   dsm_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (Q_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (dec),
      .pop       (cmd_pop),
      .pop_data  (q_data),
      .valid     (cmd_valid),
      .full      (q_full),
      .count     (q_count)
   );

`ifndef ASSERT_OFF
   a_count_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> (q_count == CW'(Q_DEPTH)))
      else $error("command queue full flag disagrees with count");
`endif

endmodule

@@ src/dsm_back.sv @@
// Back end: transition store, accepting mask, walk state and result queue.
module dsm_back import dsm_pkg::*; #(
   parameter int NUM_STATES  = 64,
   parameter int SYMBOL_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [STATE_W-1:0] csr_wr_data,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_word
);

   localparam int SB    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int AW    = SB + SYMBOL_BITS;
   localparam int DEPTH = NUM_STATES * (2 ** SYMBOL_BITS);
   localparam int CW    = $clog2(Q_DEPTH + 1);
   localparam int UW    = CW + 1;

   logic [STATE_W-1:0]    start_ff;
   logic                  clear_ff, clear_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [STATE_W-1:0]    walk_state_ff, walk_state_in;
   logic                  failed_ff, failed_in;
   logic [NUM_STATES-1:0] mask_ff, mask_in;
   stage_type             stg_ff, stg_in;
   rsp_word_type          query_word_ff, query_word_in;

   entry_type             entry;
   logic [$bits(entry_type)-1:0] ram_rd_data;
   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   entry_type             ram_wr_data;

   logic                  hit;
   logic [STATE_W-1:0]    st_res, st_iss;
   logic                  fl_res, fl_iss, look_iss;
   rsp_word_type          res_word, out_word;
   logic                  issue_match;
   logic                  deq, room;
   logic [UW-1:0]         used;
   logic                  out_push, out_full;
   logic [CW-1:0]         out_count;
   logic [$bits(rsp_word_type)-1:0] out_data;

   function automatic logic state_in_range(input logic [STATE_W-1:0] s);
      return (32'(s) < 32'(NUM_STATES));
   endfunction

   function automatic logic state_acc(input logic [STATE_W-1:0] s,
                                      input logic [NUM_STATES-1:0] m);
      logic r;
      r = 1'b0;
      if (state_in_range(s)) begin
         r = m[SB'(s)];
      end
      return r;
   endfunction

   assign clearing = clear_ff;

   // resolve the lookup issued last cycle
   always_comb begin
      entry                       = entry_type'(ram_rd_data);
      hit                         = stg_ff.match & stg_ff.look & entry.valid;
      st_res                      = hit ? entry.dest_state : walk_state_ff;
      fl_res                      = stg_ff.match ? ~hit : failed_ff;
      res_word.accepted           = ~fl_res & state_acc(st_res, mask_ff);
      res_word.missing_transition = fl_res;
      res_word.end_state          = st_res;
   end

   // issue one command per cycle while not clearing and, for a command with a result, while the result queue has room
   always_comb begin
      deq         = rsp_valid & ~rsp_stall;
      used        = UW'(out_count) + UW'(stg_ff.report) - UW'(deq);
      room        = (used < UW'(Q_DEPTH));
      cmd_pop     = cmd_valid & ~clear_ff & (~cmd.has_result | room);
      issue_match = cmd_pop & (cmd.op == OP_MATCH);

      st_iss   = cmd.first_symbol ? start_ff : st_res;
      fl_iss   = cmd.first_symbol ? 1'b0 : fl_res;
      look_iss = ~fl_iss & state_in_range(st_iss);

      ram_rd_en   = issue_match & look_iss;
      ram_rd_addr = {SB'(st_iss), cmd.symbol[SYMBOL_BITS-1:0]};

      if (clear_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = cmd_pop & (cmd.op == OP_LOAD) & cmd.in_range;
         ram_wr_addr = {SB'(cmd.from_state), cmd.symbol[SYMBOL_BITS-1:0]};
         ram_wr_data.valid      = cmd.entry_valid;
         ram_wr_data.dest_state = cmd.entry_valid ? cmd.to_state : '0;
      end

      mask_in = mask_ff;
      if (cmd_pop && (cmd.op == OP_MARK) && cmd.in_range) begin
         mask_in[SB'(cmd.from_state)] = cmd.entry_valid;
      end

      walk_state_in = issue_match ? st_iss : st_res;
      failed_in     = issue_match ? fl_iss : fl_res;

      stg_in.match  = issue_match;
      stg_in.look   = issue_match & look_iss;
      stg_in.report = cmd_pop & cmd.has_result;

      query_word_in.accepted           = state_acc(start_ff, mask_ff);
      query_word_in.missing_transition = 1'b0;
      query_word_in.end_state          = start_ff;

      clr_addr_in = clr_addr_ff + AW'(1);
      clear_in    = clear_ff & (clr_addr_ff != AW'(DEPTH - 1));

      out_push = stg_ff.report;
      out_word = stg_ff.match ? res_word : query_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= '0;
         clear_ff      <= 1'b1;
         clr_addr_ff   <= '0;
         walk_state_ff <= '0;
         failed_ff     <= 1'b0;
         mask_ff       <= '0;
         stg_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
         clear_ff      <= clear_in;
         clr_addr_ff   <= clr_addr_in;
         walk_state_ff <= walk_state_in;
         failed_ff     <= failed_in;
         mask_ff       <= mask_in;
         stg_ff        <= stg_in;
      end
   end

   always_ff @(posedge clock) begin
      query_word_ff <= query_word_in;
   end

   dsm_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_trans_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dsm_fifo #(
      .WIDTH ($bits(rsp_word_type)),
      .DEPTH (Q_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_word),
      .pop       (~rsp_stall),
      .pop_data  (out_data),
      .valid     (rsp_valid),
      .full      (out_full),
      .count     (out_count)
   );

   assign rsp_word = rsp_word_type'(out_data);

`ifndef ASSERT_OFF
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (!out_full || deq))
      else $error("result word pushed into a full result queue");

   a_no_issue_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !cmd_pop)
      else $error("command issued during transition store clear");

   a_failed_no_lookup: assert property (@(posedge clock) disable iff (reset)
      (issue_match && fl_iss) |=> !stg_ff.look)
      else $error("lookup issued for a failed string");

   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      (issue_match && cmd.first_symbol) |=>
         ((walk_state_ff == $past(start_ff)) && !failed_ff))
      else $error("first symbol did not restart the walk");
`endif

endmodule

@@ tb/sv/dsm_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard for the DFA string matcher: mirrors the automaton and checks every result word.
module dsm_scoreboard import dsm_pkg::*; #(
   parameter int NUM_STATES  = 64,
   parameter int SYMBOL_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  req_word_type       req_word,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rsp_word_type       rsp_word,
   input  logic               csr_wr_en,
   input  logic [STATE_W-1:0] csr_wr_data,
   output int                 fail_count,
   output int                 verdicts_due,
   output int                 verdicts_seen
);

   localparam int SYM_COUNT = 1 << SYMBOL_BITS;

   entry_type          next_table [NUM_STATES*SYM_COUNT];
   logic [63:0]        accept_marks;
   logic [STATE_W-1:0] walk_state;
   logic               walk_failed;
   logic [STATE_W-1:0] start_reg;
   rsp_word_type       pending_verdicts [$];

   function automatic logic is_accepting(input logic [STATE_W-1:0] st);
      return (st < NUM_STATES) && accept_marks[st];
   endfunction

   // Advance the automaton by one request word; a verdict comes out for a
   // closing match symbol or an empty-string query.
   task automatic walk_dfa(input req_word_type w, output bit produces,
                           output rsp_word_type verdict);
      int unsigned sym;
      sym = w.symbol & (SYM_COUNT - 1);
      produces = 1'b0;
      verdict = '0;
      case (w.op)
         OP_LOAD: begin
            if (w.from_state < NUM_STATES) begin
               next_table[w.from_state*SYM_COUNT + sym].valid = w.entry_valid;
               next_table[w.from_state*SYM_COUNT + sym].dest_state =
                  w.entry_valid ? w.to_state : '0;
            end
         end
         OP_MARK: begin
            if (w.from_state < NUM_STATES)
               accept_marks[w.from_state] = w.entry_valid;
         end
         OP_EMPTY: begin
            produces = 1'b1;
            verdict.accepted = is_accepting(start_reg);
            verdict.missing_transition = 1'b0;
            verdict.end_state = start_reg;
         end
         OP_MATCH: begin
            if (w.first_symbol) begin
               walk_state = start_reg;
               walk_failed = 1'b0;
            end
            if (!walk_failed) begin
               if (walk_state < NUM_STATES && next_table[walk_state*SYM_COUNT + sym].valid)
                  walk_state = next_table[walk_state*SYM_COUNT + sym].dest_state;
               else
                  walk_failed = 1'b1;
            end
            if (w.last_symbol) begin
               produces = 1'b1;
               verdict.accepted = !walk_failed && is_accepting(walk_state);
               verdict.missing_transition = walk_failed;
               verdict.end_state = walk_state;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      bit           produces;
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         foreach (next_table[i])
            next_table[i] = '0;
         accept_marks = '0;
         walk_state = '0;
         walk_failed = 1'b0;
         start_reg = '0;
         pending_verdicts.delete();
         fail_count = 0;
         verdicts_seen = 0;
      end else begin
         if (csr_wr_en)
            start_reg = csr_wr_data;
         if (req_valid && !req_stall) begin
            walk_dfa(req_word, produces, want);
            if (produces)
               pending_verdicts.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_word;
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
               $error("unexpected result word: accepted %0d missing_transition %0d end_state %0d",
                      got.accepted, got.missing_transition, got.end_state);
               fail_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (got.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                  fail_count++;
               end
               if (got.missing_transition !== want.missing_transition) begin
                  $error("missing_transition: expected %0d, got %0d",
                         want.missing_transition, got.missing_transition);
                  fail_count++;
               end
               if (got.end_state !== want.end_state) begin
                  $error("end_state: expected %0d, got %0d", want.end_state, got.end_state);
                  fail_count++;
               end
            end
         end
      end
      verdicts_due = pending_verdicts.size();
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the DFA string matcher: clock, reset, stimulus and verdict.
module tb;
   import dsm_pkg::*;

   localparam int RANDOM_WORDS = 1250;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_word_type       req_word = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_word_type       rsp_word;
   logic               csr_wr_en = 1'b0;
   logic [STATE_W-1:0] csr_wr_data = '0;

   int fail_count;
   int verdicts_due;
   int verdicts_seen;
   int words_sent = 0;
   int burst_left = 0;
   int start_writes = 0;
   int phases = 0;
   int stall_mode = 0;
   int stall_left = 0;

   dfa_string_matcher uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dsm_scoreboard board (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .verdicts_due  (verdicts_due),
      .verdicts_seen (verdicts_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: free-flowing, sparse, heavy and run-length stall stretches
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ((stall_left % 8) < 5);
      endcase
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic req_word_type make_word(input op_type op, input int from, input int sym,
                                              input int to, input int valid, input int first,
                                              input int last);
      req_word_type w;
      w.op = op;
      w.from_state = STATE_W'(from);
      w.symbol = SYM_W'(sym);
      w.to_state = STATE_W'(to);
      w.entry_valid = 1'(valid);
      w.first_symbol = 1'(first);
      w.last_symbol = 1'(last);
      return w;
   endfunction

   function automatic req_word_type noise_word();
      return make_word(op_type'($urandom_range(0, 3)), $urandom_range(0, 63),
                       $urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 1));
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      burst_left--;
      words_sent++;
   endtask

   // hold off until every outstanding result is back and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      while (verdicts_due != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_start(input logic [STATE_W-1:0] st);
      csr_wr_en <= 1'b1;
      csr_wr_data <= st;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      start_writes++;
   endtask

   initial begin : stimulus
      logic [STATE_W-1:0] states [$];
      logic [SYM_W-1:0]   alphabet [$];
      logic [STATE_W-1:0] start;
      req_word_type       w;
      int                 len;
      int                 target;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      write_start('0);

      // empty table, then a two-state loop through the extreme states and symbols
      send_word(make_word(OP_EMPTY, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_MATCH, 0, 0, 0, 0, 1, 1));
      send_word(make_word(OP_LOAD, 0, 255, 63, 1, 0, 0));
      send_word(make_word(OP_LOAD, 63, 0, 0, 1, 0, 0));
      send_word(make_word(OP_MARK, 63, 0, 0, 1, 0, 0));
      send_word(make_word(OP_MATCH, 0, 255, 0, 0, 1, 1));
      send_word(make_word(OP_MATCH, 0, 0, 0, 0, 0, 1));
      send_word(make_word(OP_MATCH, 0, 255, 0, 0, 1, 0));
      send_word(make_word(OP_EMPTY, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_MATCH, 0, 0, 0, 0, 0, 1));
      // sticky failure: symbol after a miss is not looked up
      send_word(make_word(OP_MATCH, 0, 7, 0, 0, 1, 0));
      send_word(make_word(OP_MATCH, 0, 255, 0, 0, 0, 1));
      send_word(make_word(OP_LOAD, 0, 255, 0, 0, 0, 0));
      send_word(make_word(OP_MATCH, 0, 255, 0, 0, 1, 1));
      send_word(make_word(OP_MARK, 0, 0, 0, 1, 0, 0));
      send_word(make_word(OP_EMPTY, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_MARK, 0, 0, 0, 0, 0, 0));
      drain();
      write_start(STATE_W'(63));
      send_word(make_word(OP_EMPTY, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_MATCH, 0, 0, 0, 0, 1, 1));
      // lookup right behind the load that writes its entry
      send_word(make_word(OP_LOAD, 63, 128, 42, 1, 0, 0));
      send_word(make_word(OP_MATCH, 0, 128, 0, 0, 1, 1));

      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         drain();
         phases++;
         case (phases % 4)
            0: start = '0;
            1: start = '1;
            default: start = STATE_W'($urandom_range(0, 63));
         endcase
         write_start(start);

         states.delete();
         states.push_back(start);
         repeat ($urandom_range(1, 5))
            states.push_back(STATE_W'($urandom_range(0, 63)));
         alphabet.delete();
         repeat ($urandom_range(2, 4))
            alphabet.push_back(SYM_W'($urandom_range(0, 255)));

         foreach (states[i])
            foreach (alphabet[j])
               send_word(make_word(OP_LOAD, int'(states[i]), int'(alphabet[j]),
                                   int'(states[$urandom_range(0, states.size() - 1)]),
                                   int'($urandom_range(0, 9) != 0), $urandom_range(0, 1),
                                   $urandom_range(0, 1)));
         foreach (states[i])
            send_word(make_word(OP_MARK, int'(states[i]), $urandom_range(0, 255),
                                $urandom_range(0, 63), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 1)));

         repeat ($urandom_range(4, 12)) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(0, 19))
                  0: send_word(noise_word());
                  1: send_word(make_word(OP_EMPTY, $urandom_range(0, 63), $urandom_range(0, 255),
                                         $urandom_range(0, 63), $urandom_range(0, 1),
                                         $urandom_range(0, 1), $urandom_range(0, 1)));
                  2: send_word(make_word(OP_LOAD,
                                         int'(states[$urandom_range(0, states.size() - 1)]),
                                         int'(alphabet[$urandom_range(0, alphabet.size() - 1)]),
                                         int'(states[$urandom_range(0, states.size() - 1)]),
                                         $urandom_range(0, 1), $urandom_range(0, 1),
                                         $urandom_range(0, 1)));
                  default: ;
               endcase
               w = make_word(OP_MATCH, $urandom_range(0, 63),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                                int'(alphabet[$urandom_range(0, alphabet.size() - 1)]),
                             $urandom_range(0, 63), $urandom_range(0, 1), int'(k == 0),
                             int'(k == len - 1));
               if ($urandom_range(0, 19) == 0)
                  w.first_symbol = ~w.first_symbol;
               if ($urandom_range(0, 19) == 0)
                  w.last_symbol = ~w.last_symbol;
               send_word(w);
            end
         end
      end
      drain();

      $display("%0d request words over %0d random automata, %0d result words checked",
               words_sent, phases, verdicts_seen);
      $display("start state set %0d times, including both ends of its range", start_writes);
      if (fail_count == 0 && verdicts_due == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
